FILE: rtl/parent_pointer_forest_engine_defines.svh
// assertion macros shared by the forest engine rtl
`ifndef PARENT_POINTER_FOREST_ENGINE_DEFINES_SVH
`define PARENT_POINTER_FOREST_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PPFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PPFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ppfe_pkg.sv
// shared constants, request codes and sequencer states of the forest engine
`default_nettype none

package ppfe_pkg;

    localparam int PPFE_MAX_NODES  = 1024;
    localparam int PPFE_COST_BITS  = 32;
    localparam int PPFE_STAMP_BITS = 16;

    localparam int NODE_W  = 11;
    localparam int COUNT_W = 11;

    // config register byte addresses
    localparam logic [1:0] ADDR_NODE_COUNT = 2'd0;

    localparam logic [3:0] REQ_LINK     = 4'd0;
    localparam logic [3:0] REQ_CUT      = 4'd1;
    localparam logic [3:0] REQ_REROOT   = 4'd2;
    localparam logic [3:0] REQ_LCA      = 4'd3;
    localparam logic [3:0] REQ_DEPTH    = 4'd4;
    localparam logic [3:0] REQ_GET_NODE = 4'd5;
    localparam logic [3:0] REQ_SET_COST = 4'd6;
    localparam logic [3:0] REQ_GET_COST = 4'd7;
    localparam logic [3:0] REQ_PATH_ADD = 4'd8;
    localparam logic [3:0] REQ_PATH_MIN = 4'd9;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STAMP,
        ST_WIPE,
        ST_LCA,
        ST_REROOT,
        ST_CUT_U,
        ST_CUT_V,
        ST_SINGLE,
        ST_WALK,
        ST_CLIMB,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/ppfe_ram.sv
// single-port-write, single-port-read synchronous ram with write forwarding
`default_nettype none

module ppfe_ram #(
    parameter int DEPTH = 1025,
    parameter int WIDTH = 43
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // a read of the entry written in the same cycle returns the new data
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/parent_pointer_forest_engine.sv
// top level of the forest engine: config register, request sequencer and node memories
`default_nettype none

// parent_pointer_forest_engine keeps a forest of nodes 1..node_count as a parent table
// with a signed weight per node and serves one request at a time.
// input channel: in_valid / in_stall carry req_type, node_u, node_v, depth_arg and
// cost_arg; a request is taken when in_valid is high and in_stall is low.
// output channel: out_valid / out_stall carry result_node, result_value and status,
// one result per request, in request order.
// config: apb-style port, register node_count at byte address 0.
// work per request: every pointer chase reads the node memory once a cycle; a walk
// visits each node on its path, an lca up to the sum of both depths, a link is an
// lca plus a reroot, and get_node with a nonnegative depth a walk, then a climb if
// the target lies above the node.
// when the visit stamp counter wraps, the stamps of nodes 1..node_count are wiped first,
// one node a cycle.
// reset: after rst_n rises the block clears all MAX_NODES+1 entries of its memories,
// one a cycle, and holds in_stall high meanwhile; config writes are taken throughout.
// a finished result sits in the output register; a new request is taken while it waits,
// and the next result waits for out_stall to drop.

module parent_pointer_forest_engine #(
    parameter int MAX_NODES  = ppfe_pkg::PPFE_MAX_NODES,
    parameter int COST_BITS  = ppfe_pkg::PPFE_COST_BITS,
    parameter int STAMP_BITS = ppfe_pkg::PPFE_STAMP_BITS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [1:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,

    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [3:0]                 req_type,
    input  wire logic [ppfe_pkg::NODE_W-1:0] node_u,
    input  wire logic [ppfe_pkg::NODE_W-1:0] node_v,
    input  wire logic signed [11:0]         depth_arg,
    input  wire logic signed [31:0]         cost_arg,

    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [ppfe_pkg::NODE_W-1:0]     result_node,
    output logic signed [31:0]              result_value,
    output logic                            status
);

    import ppfe_pkg::*;

    `include "parent_pointer_forest_engine_defines.svh"

    localparam int DEPTH = MAX_NODES + 1;
    localparam int ID_W  = $clog2(DEPTH);
    localparam int CMP_W = (ID_W > COUNT_W) ? ID_W : COUNT_W;
    localparam int DW    = ((ID_W > 12) ? ID_W : 12) + 3;
    localparam int NW    = ID_W + COST_BITS;

    localparam logic [CMP_W-1:0] MAX_C   = CMP_W'(MAX_NODES);
    localparam logic [ID_W-1:0]  LAST_ID = ID_W'(MAX_NODES);

    // config register
    logic [COUNT_W-1:0] node_count_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_NODE_COUNT);
    assign prdata = (paddr == ADDR_NODE_COUNT) ? 32'(node_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= COUNT_W'(MAX_NODES);
        end
        else if (cfg_wr)
        begin
            node_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // effective node count and id screening
    logic [CMP_W-1:0] nc_w;
    logic [CMP_W-1:0] ce;
    logic [CMP_W-1:0] u_raw;
    logic [CMP_W-1:0] v_raw;
    logic [ID_W-1:0]  u_id;
    logic [ID_W-1:0]  v_id;

    assign nc_w  = CMP_W'(node_count_reg);
    assign ce    = (nc_w == '0) ? CMP_W'(1) : ((nc_w > MAX_C) ? MAX_C : nc_w);
    assign u_raw = CMP_W'(node_u);
    assign v_raw = CMP_W'(node_v);
    assign u_id  = ((u_raw == '0) || (u_raw > ce)) ? '0 : ID_W'(u_raw);
    assign v_id  = ((v_raw == '0) || (v_raw > ce)) ? '0 : ID_W'(v_raw);

    // node memory holds {parent, weight}; stamp memory holds the visit stamps
    logic              node_we;
    logic [ID_W-1:0]   node_waddr;
    logic [NW-1:0]     node_wdata;
    logic [NW-1:0]     node_rd;
    logic              stamp_we;
    logic [ID_W-1:0]   stamp_waddr;
    logic [STAMP_BITS-1:0] stamp_wdata;
    logic [STAMP_BITS-1:0] stamp_rd;
    logic [ID_W-1:0]   rd_addr;

    ppfe_ram #(
        .DEPTH (DEPTH),
        .WIDTH (NW)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (rd_addr),
        .rdata (node_rd)
    );

    ppfe_ram #(
        .DEPTH (DEPTH),
        .WIDTH (STAMP_BITS)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (stamp_waddr),
        .wdata (stamp_wdata),
        .raddr (rd_addr),
        .rdata (stamp_rd)
    );

    logic [ID_W-1:0]      p_rd;
    logic [COST_BITS-1:0] w_rd;

    assign p_rd = node_rd[NW-1:COST_BITS];
    assign w_rd = node_rd[COST_BITS-1:0];

    // sequencer registers
    state_t               state_reg,      state_next;
    logic [3:0]           req_reg,        req_next;
    logic [ID_W-1:0]      nu_reg,         nu_next;
    logic [ID_W-1:0]      nv_reg,         nv_next;
    logic [ID_W-1:0]      cur_reg,        cur_next;
    logic [ID_W-1:0]      other_reg,      other_next;
    logic [ID_W-1:0]      below_reg,      below_next;
    logic [ID_W-1:0]      clr_reg,        clr_next;
    logic [ID_W-1:0]      rnode_reg,      rnode_next;
    logic signed [DW-1:0] cnt_reg,        cnt_next;
    logic signed [11:0]   d_reg,          d_next;
    logic [COST_BITS-1:0] cost_reg,       cost_next;
    logic [COST_BITS-1:0] minw_reg,       minw_next;
    logic [COST_BITS-1:0] wu_reg,         wu_next;
    logic [31:0]          rval_reg,       rval_next;
    logic                 status_reg,     status_next;
    logic [STAMP_BITS-1:0] stamp_cnt_reg, stamp_cnt_next;
    logic                 out_valid_reg,  out_valid_next;
    logic [NODE_W-1:0]    res_node_reg,   res_node_next;
    logic [31:0]          res_value_reg,  res_value_next;
    logic                 res_status_reg, res_status_next;

    logic                  in_acc;
    logic [63:0]           cost_ext;
    logic [COST_BITS-1:0]  cost_in;
    logic [63:0]           w_ext;
    logic signed [DW-1:0]  d_ext;
    logic signed [DW-1:0]  rem;
    logic signed [DW-1:0]  neg_d;
    logic [STAMP_BITS-1:0] stamp_inc;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cost_ext  = {{32{cost_arg[31]}}, cost_arg};
    assign cost_in   = cost_ext[COST_BITS-1:0];
    assign w_ext     = 64'($signed(w_rd));
    assign d_ext     = DW'(d_reg);
    assign rem       = d_ext - cnt_reg;
    assign neg_d     = -DW'(depth_arg);
    assign stamp_inc = stamp_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            stamp_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            stamp_cnt_reg <= stamp_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        nu_reg         <= nu_next;
        nv_reg         <= nv_next;
        cur_reg        <= cur_next;
        other_reg      <= other_next;
        below_reg      <= below_next;
        rnode_reg      <= rnode_next;
        cnt_reg        <= cnt_next;
        d_reg          <= d_next;
        cost_reg       <= cost_next;
        minw_reg       <= minw_next;
        wu_reg         <= wu_next;
        rval_reg       <= rval_next;
        status_reg     <= status_next;
        res_node_reg   <= res_node_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        nu_next         = nu_reg;
        nv_next         = nv_reg;
        cur_next        = cur_reg;
        other_next      = other_reg;
        below_next      = below_reg;
        clr_next        = clr_reg;
        rnode_next      = rnode_reg;
        cnt_next        = cnt_reg;
        d_next          = d_reg;
        cost_next       = cost_reg;
        minw_next       = minw_reg;
        wu_next         = wu_reg;
        rval_next       = rval_reg;
        status_next     = status_reg;
        stamp_cnt_next  = stamp_cnt_reg;
        res_node_next   = res_node_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;

        rd_addr     = cur_reg;
        node_we     = 1'b0;
        node_waddr  = cur_reg;
        node_wdata  = {p_rd, w_rd};
        stamp_we    = 1'b0;
        stamp_waddr = cur_reg;
        stamp_wdata = stamp_cnt_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                node_we     = 1'b1;
                node_waddr  = clr_reg;
                node_wdata  = '0;
                stamp_we    = 1'b1;
                stamp_waddr = clr_reg;
                stamp_wdata = '0;
                if (clr_reg == LAST_ID)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (in_acc)
                begin
                    req_next    = req_type;
                    nu_next     = u_id;
                    nv_next     = v_id;
                    d_next      = depth_arg;
                    cost_next   = cost_in;
                    rnode_next  = '0;
                    rval_next   = '0;
                    status_next = 1'b0;
                    cnt_next    = '0;
                    below_next  = '0;
                    cur_next    = v_id;
                    other_next  = u_id;
                    rd_addr     = v_id;
                    case (req_type)
                        REQ_LINK:
                        begin
                            state_next = (u_id == '0) ? ST_DONE : ST_STAMP;
                        end
                        REQ_CUT:
                        begin
                            cur_next   = u_id;
                            rd_addr    = u_id;
                            state_next = (u_id == '0) ? ST_DONE : ST_CUT_U;
                        end
                        REQ_REROOT:
                        begin
                            state_next = ST_REROOT;
                        end
                        REQ_LCA:
                        begin
                            state_next = ST_STAMP;
                        end
                        REQ_DEPTH, REQ_PATH_ADD:
                        begin
                            state_next = ST_WALK;
                        end
                        REQ_PATH_MIN:
                        begin
                            rnode_next = v_id;
                            state_next = ST_WALK;
                        end
                        REQ_GET_NODE:
                        begin
                            // negative depth climbs straight away
                            if (depth_arg < 0)
                            begin
                                cnt_next   = neg_d;
                                state_next = ST_CLIMB;
                            end
                            else
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        REQ_SET_COST, REQ_GET_COST:
                        begin
                            state_next = ST_SINGLE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_STAMP:
            begin
                if (stamp_inc == '0)
                begin
                    stamp_cnt_next = STAMP_BITS'(1);
                    clr_next       = ID_W'(1);
                    state_next     = ST_WIPE;
                end
                else
                begin
                    stamp_cnt_next = stamp_inc;
                    state_next     = ST_LCA;
                end
            end

            ST_WIPE:
            begin
                stamp_we    = 1'b1;
                stamp_waddr = clr_reg;
                stamp_wdata = '0;
                if (clr_reg == ID_W'(ce))
                begin
                    state_next = ST_LCA;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            ST_LCA:
            begin
                // walks alternate between the two paths; first node seen twice wins
                if ((cur_reg == '0) || (stamp_rd == stamp_cnt_reg))
                begin
                    if (req_reg == REQ_LINK)
                    begin
                        if (cur_reg != '0)
                        begin
                            status_next = 1'b1;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            // reroot u with v as the new parent of u
                            cur_next   = nu_reg;
                            below_next = nv_reg;
                            rd_addr    = nu_reg;
                            state_next = ST_REROOT;
                        end
                    end
                    else
                    begin
                        rnode_next = cur_reg;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    stamp_we = 1'b1;
                    if (other_reg != '0)
                    begin
                        cur_next   = other_reg;
                        other_next = p_rd;
                        rd_addr    = other_reg;
                    end
                    else
                    begin
                        cur_next = p_rd;
                        rd_addr  = p_rd;
                    end
                end
            end

            ST_REROOT:
            begin
                if (cur_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    node_we    = 1'b1;
                    node_wdata = {below_reg, w_rd};
                    below_next = cur_reg;
                    cur_next   = p_rd;
                    rd_addr    = p_rd;
                end
            end

            ST_CUT_U:
            begin
                below_next = p_rd;
                wu_next    = w_rd;
                if (nv_reg == '0)
                begin
                    cur_next = p_rd;
                    rd_addr  = p_rd;
                end
                else
                begin
                    cur_next = nv_reg;
                    rd_addr  = nv_reg;
                end
                if ((nv_reg == '0) && (p_rd == '0))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_CUT_V;
                end
            end

            ST_CUT_V:
            begin
                // below_reg holds the parent of u, cur_reg the resolved v
                if (p_rd == nu_reg)
                begin
                    node_we    = 1'b1;
                    node_wdata = {ID_W'(0), w_rd};
                    rnode_next = cur_reg;
                end
                else if (below_reg == cur_reg)
                begin
                    node_we    = 1'b1;
                    node_waddr = nu_reg;
                    node_wdata = {ID_W'(0), wu_reg};
                    rnode_next = nu_reg;
                end
                state_next = ST_DONE;
            end

            ST_SINGLE:
            begin
                if (cur_reg != '0)
                begin
                    if (req_reg == REQ_SET_COST)
                    begin
                        node_we    = 1'b1;
                        node_wdata = {p_rd, cost_reg};
                    end
                    else
                    begin
                        rval_next = w_ext[31:0];
                    end
                end
                state_next = ST_DONE;
            end

            ST_WALK:
            begin
                if (cur_reg == '0)
                begin
                    state_next = ST_DONE;
                    if (req_reg == REQ_DEPTH)
                    begin
                        rval_next = 32'(cnt_reg);
                    end
                    else if (req_reg == REQ_GET_NODE)
                    begin
                        // target depth relative to the node: below, at it, or above
                        if (rem > 0)
                        begin
                            rnode_next = '0;
                        end
                        else if (rem == 0)
                        begin
                            rnode_next = nv_reg;
                        end
                        else
                        begin
                            cnt_next   = -rem;
                            cur_next   = nv_reg;
                            rd_addr    = nv_reg;
                            state_next = ST_CLIMB;
                        end
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (req_reg == REQ_PATH_ADD)
                    begin
                        node_we    = 1'b1;
                        node_wdata = {p_rd, w_rd + cost_reg};
                    end
                    if ((req_reg == REQ_PATH_MIN) &&
                        ((cnt_reg == 0) || ($signed(w_rd) < $signed(minw_reg))))
                    begin
                        rnode_next = cur_reg;
                        minw_next  = w_rd;
                    end
                    cur_next = p_rd;
                    rd_addr  = p_rd;
                end
            end

            ST_CLIMB:
            begin
                if ((cur_reg == '0) || (cnt_reg == 0))
                begin
                    rnode_next = cur_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                    cur_next = p_rd;
                    rd_addr  = p_rd;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    res_node_next   = NODE_W'(rnode_reg);
                    res_value_next  = rval_reg;
                    res_status_next = status_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign result_node  = res_node_reg;
    assign result_value = res_value_reg;
    assign status       = res_status_reg;

    `PPFE_ASSERT_NEXT(a_accept_starts_work, in_acc, state_reg != ST_IDLE, "accepted but idle")
    `PPFE_ASSERT_NOW(a_lca_stamp_nonzero, state_reg == ST_LCA, stamp_cnt_reg != '0, "stamp zero")
    `PPFE_ASSERT_NOW(a_lca_no_node_write, state_reg == ST_LCA, !node_we, "lca wrote node ram")
    `PPFE_ASSERT_NOW(a_wipe_in_range, state_reg == ST_WIPE, (clr_reg != '0) && (clr_reg <= ID_W'(ce)), "wipe range")

endmodule

`default_nettype wire
